FILE: src/shortest_queue_dispatcher_defines.svh
// assertion macros for the shortest queue dispatcher checker
// no dependencies; included by the checker file only
`ifndef SHORTEST_QUEUE_DISPATCHER_DEFINES_SVH
`define SHORTEST_QUEUE_DISPATCHER_DEFINES_SVH

// same-cycle implication, held off during reset
`define SQD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sqd check failed");

// next-cycle implication, held off during reset
`define SQD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sqd check failed");

`endif

FILE: src/sqd_pkg.sv
// shared types and fixed field widths for the shortest queue dispatcher
// no dependencies
package sqd_pkg;

    localparam int CUST_W   = 16;
    localparam int LEN_W    = 5;
    localparam int CHOSEN_W = 2;
    localparam int REPORTED = 3;
    localparam int OUT_W    = 72;

    typedef enum logic
    {
        CMD_ENQUEUE = 1'b0,
        CMD_SERVE   = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic push;
        logic pop;
    } q_ctrl_t;

endpackage

FILE: src/sqd_queue.sv
// one bounded fifo: storage, read and write pointers, fill counter, registered head read
// depends on sqd_pkg
module sqd_queue #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sqd_pkg::q_ctrl_t              ctrl,
    input  logic [sqd_pkg::CUST_W-1:0]    din,
    output logic [$clog2(DEPTH+1)-1:0]    count,
    output logic [sqd_pkg::CUST_W-1:0]    head
);
    import sqd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CUST_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CUST_W-1:0] head_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (ctrl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (ctrl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({ctrl.push, ctrl.pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wr_ptr_reg] <= din;
        end
        if (ctrl.pop)
        begin
            head_reg <= mem[rd_ptr_reg];
        end
    end

    assign count = count_reg;
    assign head  = head_reg;

endmodule

FILE: src/sqd_select.sv
// picks the queue with the lowest fill count, lowest index on a tie
// depends on sqd_pkg
module sqd_select #(
    parameter int NUM_QUEUES = 3,
    parameter int CNT_W      = 5
) (
    input  logic [NUM_QUEUES-1:0][CNT_W-1:0] counts,
    output logic [$clog2(NUM_QUEUES)-1:0]    best
);
    import sqd_pkg::*;

    localparam int QIDX_W = $clog2(NUM_QUEUES);

    logic [QIDX_W-1:0] best_idx;
    logic [CNT_W-1:0]  best_cnt;

    always_comb
    begin
        best_idx = '0;
        best_cnt = counts[0];
        for (int q = 1; q < NUM_QUEUES; q++)
        begin
            if (counts[q] < best_cnt)
            begin
                best_idx = QIDX_W'(q);
                best_cnt = counts[q];
            end
        end
    end

    assign best = best_idx;

endmodule

FILE: src/shortest_queue_dispatcher.sv
// channel   | accept                        | payload
// s_axis    | s_axis_tvalid & s_axis_tready | tuser: cmd, tdata: customer
// m_axis    | m_axis_tvalid & m_axis_tready | tdata: choice, serve results, fill counts
//
// one beat is taken every clock while no result waits on m_axis; its result is registered and shown the cycle after
// the choice and every fifo pointer and counter update finish in that single cycle
// reset clears pointers, fill counts and the output valid; stored customers are not cleared
// s_axis_tready drops only while a result waits on m_axis
// top level of the shortest queue dispatcher
// depends on sqd_pkg, sqd_queue, sqd_select
module shortest_queue_dispatcher #(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUM_QUEUES  = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,   // [15:0] customer
    input  logic                        s_axis_tuser,   // [0] cmd
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [1:0] chosen_queue, [2] accepted, [3] served_valid_a, [19:4] served_value_a,
    // [20] served_valid_b, [36:21] served_value_b, [37] served_valid_c,
    // [53:38] served_value_c, [58:54] length_a, [63:59] length_b, [68:64] length_c,
    // [71:69] zero
    output logic [sqd_pkg::OUT_W-1:0]   m_axis_tdata
);
    import sqd_pkg::*;

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int QIDX_W = $clog2(NUM_QUEUES);

    logic                                accept;
    logic                                enq;
    logic                                serve;
    logic [NUM_QUEUES-1:0][CNT_W-1:0]    counts;
    logic [NUM_QUEUES-1:0][CUST_W-1:0]   heads;
    logic [QIDX_W-1:0]                   best;
    logic                                best_full;
    q_ctrl_t [NUM_QUEUES-1:0]            ctrl;
    logic [NUM_QUEUES-1:0]               pops;

    logic                                m_valid_reg;
    logic                                m_valid_next;
    logic [CHOSEN_W-1:0]                 chosen_reg;
    logic                                accepted_reg;
    logic [NUM_QUEUES-1:0]               served_reg;

    logic [REPORTED-1:0]                 rep_valid;
    logic [REPORTED-1:0][CUST_W-1:0]     rep_value;
    logic [REPORTED-1:0][LEN_W-1:0]      rep_len;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign enq           = accept && (cmd_t'(s_axis_tuser) == CMD_ENQUEUE);
    assign serve         = accept && (cmd_t'(s_axis_tuser) == CMD_SERVE);

    sqd_select #(
        .NUM_QUEUES (NUM_QUEUES),
        .CNT_W      (CNT_W)
    ) u_select (
        .counts (counts),
        .best   (best)
    );

    assign best_full = (counts[best] == CNT_W'(QUEUE_DEPTH));

    for (genvar q = 0; q < NUM_QUEUES; q++)
    begin : g_queue
        assign pops[q]      = serve && (counts[q] != '0);
        assign ctrl[q].pop  = pops[q];
        assign ctrl[q].push = enq && (best == QIDX_W'(q)) && !best_full;

        sqd_queue #(
            .DEPTH (QUEUE_DEPTH)
        ) u_queue (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl[q]),
            .din   (s_axis_tdata),
            .count (counts[q]),
            .head  (heads[q])
        );
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (accept)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            chosen_reg   <= enq ? CHOSEN_W'(best) : '0;
            accepted_reg <= enq && !best_full;
            served_reg   <= pops;
        end
    end

    // counters and head registers only move on an accepted beat, so they hold this result
    for (genvar r = 0; r < REPORTED; r++)
    begin : g_report
        if (r < NUM_QUEUES)
        begin : g_present
            assign rep_valid[r] = served_reg[r];
            assign rep_value[r] = served_reg[r] ? heads[r] : '0;
            assign rep_len[r]   = LEN_W'(counts[r]);
        end
        else
        begin : g_absent
            assign rep_valid[r] = 1'b0;
            assign rep_value[r] = '0;
            assign rep_len[r]   = '0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000,
                            rep_len[2], rep_len[1], rep_len[0],
                            rep_value[2], rep_valid[2],
                            rep_value[1], rep_valid[1],
                            rep_value[0], rep_valid[0],
                            accepted_reg, chosen_reg};

endmodule

FILE: src/sqd_checker.sv
// port-level checks on the shortest queue dispatcher, bound to the top level
// depends on shortest_queue_dispatcher_defines.svh
`include "shortest_queue_dispatcher_defines.svh"

module sqd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);

    // a held result keeps its beat
    `SQD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // input is never stalled while no result is pending
    `SQD_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !m_axis_tvalid, s_axis_tready)

    // a stored enqueue reports no served customer
    `SQD_ASSERT_NOW(a_enq_no_serve, clk, rst_n, m_axis_tvalid && m_axis_tdata[2], !m_axis_tdata[3] && !m_axis_tdata[20] && !m_axis_tdata[37])

    // a result with nothing popped from any queue reports zero values
    `SQD_ASSERT_NOW(a_idle_value_zero, clk, rst_n, m_axis_tvalid && !m_axis_tdata[3] && !m_axis_tdata[20] && !m_axis_tdata[37], m_axis_tdata[19:4] == 16'h0 && m_axis_tdata[36:21] == 16'h0 && m_axis_tdata[53:38] == 16'h0)

    // every accepted beat yields a result on the next cycle
    `SQD_ASSERT_NEXT(a_result_follows, clk, rst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid)

endmodule

bind shortest_queue_dispatcher sqd_checker u_sqd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
